// ----- src/sdeq_pkg.sv -----
`timescale 1ns / 1ps

package sdeq_pkg;

   localparam int KEY_W    = 32;
   localparam int TAG_W    = 16;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE    = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   // broadcast command to every cell
   typedef struct packed {
      logic insert;
      logic pop_front;
      logic delete_step;
   } cell_ctl_type;

   // per-cell compare results
   typedef struct packed {
      logic cond;   // unoccupied, or key >= command key
      logic match;  // occupied and key == command key
   } cell_flags_type;

endpackage

// ----- src/sdeq_if.sv -----
`timescale 1ns / 1ps

interface sdeq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [sdeq_pkg::OP_W-1:0]             opcode;
   logic signed [sdeq_pkg::KEY_W-1:0]     key;
   logic [sdeq_pkg::TAG_W-1:0]            tag;

   modport source (output valid, output opcode, output key, output tag, input ready);
   modport sink   (input valid, input opcode, input key, input tag, output ready);
endinterface

interface sdeq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [sdeq_pkg::STATUS_W-1:0]         status;
   logic signed [sdeq_pkg::KEY_W-1:0]     out_key;
   logic [sdeq_pkg::TAG_W-1:0]            out_tag;
   logic [sdeq_pkg::FILL_W-1:0]           fill_count;

   modport source (output valid, output status, output out_key, output out_tag,
                   output fill_count, input ready);
   modport sink   (input valid, input status, input out_key, input out_tag,
                   input fill_count, output ready);
endinterface

// ----- src/sdeq_cell.sv -----
`timescale 1ns / 1ps

module sdeq_cell (
   input  logic                               clock,
   input  sdeq_pkg::cell_ctl_type             ctl,
   input  logic                               occupied,
   input  logic signed [sdeq_pkg::KEY_W-1:0]  cmd_key,
   input  logic [sdeq_pkg::TAG_W-1:0]         cmd_tag,
   input  logic signed [sdeq_pkg::KEY_W-1:0]  left_key,
   input  logic [sdeq_pkg::TAG_W-1:0]         left_tag,
   input  logic                               left_cond,
   input  logic signed [sdeq_pkg::KEY_W-1:0]  right_key,
   input  logic [sdeq_pkg::TAG_W-1:0]         right_tag,
   output logic signed [sdeq_pkg::KEY_W-1:0]  key,
   output logic [sdeq_pkg::TAG_W-1:0]         tag,
   output sdeq_pkg::cell_flags_type           flags
);

   logic signed [sdeq_pkg::KEY_W-1:0] key_ff, key_in;
   logic [sdeq_pkg::TAG_W-1:0]        tag_ff, tag_in;
   logic                              ge;

   assign ge          = key_ff >= cmd_key;
   assign flags.cond  = !occupied || ge;
   assign flags.match = occupied && (key_ff == cmd_key);
   assign key         = key_ff;
   assign tag         = tag_ff;

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      priority if (ctl.insert && flags.cond) begin
         if (left_cond) begin
            key_in = left_key;
            tag_in = left_tag;
         end else begin
            key_in = cmd_key;
            tag_in = cmd_tag;
         end
      end else if (ctl.pop_front || (ctl.delete_step && occupied && ge)) begin
         key_in = right_key;
         tag_in = right_tag;
      end else begin
         key_in = key_ff;
         tag_in = tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

// ----- src/sorted_double_ended_queue.sv -----
`timescale 1ns / 1ps

// Sorted double-ended priority queue over a row of DEPTH cells, cell 0 holding the
// smallest key. Every cell compares its key with the command key at once and moves
// its entry one place left or right per cycle. Insert, pop front, pop rear, lookup and
// unused opcodes are accepted in IDLE and finish in EXEC. Delete removes one matching
// entry per cycle while it stays in EXEC, since equal keys sit next to each other, and
// finishes once no match is left. A new item is taken in IDLE once the result register is
// free or being drained in the same cycle. Equal keys pop from the front newest first.
module sorted_double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   sdeq_req_if.sink    req_ch,
   sdeq_rsp_if.source  rsp_ch
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      IDLE = 2'b01,
      EXEC = 2'b10
   } state_type;

   state_type                            state_ff, state_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic                                 found_ff, found_in;
   logic [sdeq_pkg::OP_W-1:0]            op_ff;
   logic signed [sdeq_pkg::KEY_W-1:0]    cmd_key_ff;
   logic [sdeq_pkg::TAG_W-1:0]           cmd_tag_ff;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [sdeq_pkg::STATUS_W-1:0]        status_ff, status_in;
   logic signed [sdeq_pkg::KEY_W-1:0]    out_key_ff, out_key_in;
   logic [sdeq_pkg::TAG_W-1:0]           out_tag_ff, out_tag_in;
   logic [sdeq_pkg::FILL_W-1:0]          fill_ff, fill_in;

   sdeq_pkg::cell_ctl_type               ctl;
   sdeq_pkg::cell_flags_type             flags [DEPTH];
   logic signed [sdeq_pkg::KEY_W-1:0]    key_q [DEPTH];
   logic [sdeq_pkg::TAG_W-1:0]           tag_q [DEPTH];
   logic [DEPTH-1:0]                     occ, last, first, match_vec;

   logic                                 accept, empty, full, any_match;
   logic signed [sdeq_pkg::KEY_W-1:0]    rear_key, hit_key;
   logic [sdeq_pkg::TAG_W-1:0]           rear_tag, hit_tag;

   assign req_ch.ready = (state_ff == IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.out_key    = out_key_ff;
   assign rsp_ch.out_tag    = out_tag_ff;
   assign rsp_ch.fill_count = fill_ff;

   assign empty     = count_ff == '0;
   assign full      = count_ff == CW'(DEPTH);
   assign any_match = |match_vec;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [sdeq_pkg::KEY_W-1:0] lkey, rkey;
      logic [sdeq_pkg::TAG_W-1:0]        ltag, rtag;
      logic                              lcond;

      assign occ[g]       = count_ff > CW'(g);
      assign last[g]      = count_ff == CW'(g + 1);
      assign match_vec[g] = flags[g].match;

      if (g == 0) begin : g_left_edge
         assign lkey     = cmd_key_ff;
         assign ltag     = cmd_tag_ff;
         assign lcond    = 1'b0;
         assign first[g] = flags[g].match;
      end else begin : g_left
         assign lkey     = key_q[g-1];
         assign ltag     = tag_q[g-1];
         assign lcond    = flags[g-1].cond;
         assign first[g] = flags[g].match && !flags[g-1].match;
      end

      if (g == DEPTH - 1) begin : g_right_edge
         assign rkey = key_q[g];
         assign rtag = tag_q[g];
      end else begin : g_right
         assign rkey = key_q[g+1];
         assign rtag = tag_q[g+1];
      end

      sdeq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occupied  (occ[g]),
         .cmd_key   (cmd_key_ff),
         .cmd_tag   (cmd_tag_ff),
         .left_key  (lkey),
         .left_tag  (ltag),
         .left_cond (lcond),
         .right_key (rkey),
         .right_tag (rtag),
         .key       (key_q[g]),
         .tag       (tag_q[g]),
         .flags     (flags[g])
      );
   end

   always_comb begin
      rear_key = '0;
      rear_tag = '0;
      hit_key  = '0;
      hit_tag  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (last[i]) begin
            rear_key = rear_key | key_q[i];
            rear_tag = rear_tag | tag_q[i];
         end
         if (first[i]) begin
            hit_key = hit_key | key_q[i];
            hit_tag = hit_tag | tag_q[i];
         end
      end
   end

   always_comb begin
      logic done;
      state_in     = state_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      ctl          = '0;
      done         = 1'b0;
      status_in    = sdeq_pkg::ST_OK;
      out_key_in   = '0;
      out_tag_in   = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               state_in = EXEC;
               found_in = 1'b0;
            end
         end
         EXEC: begin
            done = 1'b1;
            unique case (op_ff)
               sdeq_pkg::OP_INSERT: begin
                  if (full) begin
                     status_in = sdeq_pkg::ST_FULL;
                  end else begin
                     ctl.insert = 1'b1;
                     count_in   = count_ff + CW'(1);
                  end
               end
               sdeq_pkg::OP_DELETE: begin
                  if (empty && !found_ff) begin
                     status_in = sdeq_pkg::ST_EMPTY;
                  end else if (any_match) begin
                     ctl.delete_step = 1'b1;
                     count_in        = count_ff - CW'(1);
                     found_in        = 1'b1;
                     done            = 1'b0;
                  end else begin
                     status_in = found_ff ? sdeq_pkg::ST_OK : sdeq_pkg::ST_NOTFOUND;
                  end
               end
               sdeq_pkg::OP_POP_FRONT: begin
                  if (empty) begin
                     status_in = sdeq_pkg::ST_EMPTY;
                  end else begin
                     ctl.pop_front = 1'b1;
                     count_in      = count_ff - CW'(1);
                     out_key_in    = key_q[0];
                     out_tag_in    = tag_q[0];
                  end
               end
               sdeq_pkg::OP_POP_REAR: begin
                  if (empty) begin
                     status_in = sdeq_pkg::ST_EMPTY;
                  end else begin
                     count_in   = count_ff - CW'(1);
                     out_key_in = rear_key;
                     out_tag_in = rear_tag;
                  end
               end
               sdeq_pkg::OP_LOOKUP: begin
                  if (empty) begin
                     status_in = sdeq_pkg::ST_EMPTY;
                  end else if (any_match) begin
                     out_key_in = hit_key;
                     out_tag_in = hit_tag;
                  end else begin
                     status_in = sdeq_pkg::ST_NOTFOUND;
                  end
               end
               default: begin
                  status_in = sdeq_pkg::ST_OK;
               end
            endcase
            if (done) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      fill_in = sdeq_pkg::FILL_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_ch.opcode;
         cmd_key_ff <= req_ch.key;
         cmd_tag_ff <= req_ch.tag;
      end
      if ((state_ff == EXEC) && rsp_valid_in) begin
         status_ff  <= status_in;
         out_key_ff <= out_key_in;
         out_tag_ff <= out_tag_in;
         fill_ff    <= fill_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == EXEC |-> !rsp_valid_ff)
      else $error("result register busy while executing");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == IDLE |=> $stable(count_ff))
      else $error("entry count changed while idle");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == EXEC)
      else $error("accepted item not executed");

endmodule
